FILE: hdl/best_attribute_linear_fit_defines.svh
// Assertion macros used by the checker file of the linear fit block.
// Depends on nothing; the user supplies clk and rst in scope.
`ifndef BEST_ATTRIBUTE_LINEAR_FIT_DEFINES_SVH
`define BEST_ATTRIBUTE_LINEAR_FIT_DEFINES_SVH

// Clocked check, muted while reset is high.
`define BLF_CHECK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also holds during reset.
`define BLF_CHECK_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hdl/blf_pkg.sv
// Types, codes and helpers shared by the linear fit block.
// No dependencies.
package blf_pkg;

  localparam int QW = 48;

  localparam logic CFG_USE_WEIGHTS = 1'b0;
  localparam logic CFG_NUM_ATTRS   = 1'b1;

  typedef enum logic [1:0] {
    ACT_HEADER, ACT_VALUE, ACT_FINISH, ACT_PREDICT
  } action_t;

  typedef enum logic [1:0] {
    FIT_OK, FIT_NO_ATTR, FIT_ZERO_W, FIT_OVERFLOW
  } fit_status_t;

  typedef enum logic [3:0] {
    STEP_P1, STEP_P2, STEP_P3, STEP_P4, STEP_C1, STEP_C2, STEP_B1, STEP_B2,
    STEP_SLOPE, STEP_PI, STEP_ICPT
  } step_t;

  typedef enum logic [4:0] {
    S_IDLE, S_HDR_A, S_HDR_B, S_VAL_A, S_VAL_B, S_VAL_C, S_PRED_A, S_PRED_B,
    S_FIN, S_SCAN, S_GO, S_WAIT, S_JUDGE, S_JUDGE2, S_TAKE, S_NEXT, S_EMIT
  } state_t;

  typedef struct packed {
    logic        load;
    logic        hdr_commit;
    logic        val_commit;
    logic        pred_emit;
    logic        fin_clear;
    logic        go;
    step_t       step;
    logic        take;
    logic        cnt_inc;
    logic        fit_emit;
    fit_status_t fit_status;
  } dp_cmd_t;

  typedef struct packed {
    logic overflow;
    logic w_zero;
    logic scan_end;
    logic sxx_zero;
    logic found;
    logic better;
    logic unit_done;
  } dp_stat_t;

  function automatic logic [QW-1:0] sat_q(input logic [127:0] q, input logic neg);
    logic [127:0] nq;
    nq = ~q + 128'd1;
    if (neg) begin
      if (q > {80'd0, 1'b1, 47'd0}) return {1'b1, 47'd0};
      return nq[QW-1:0];
    end
    if (q > {81'd0, {47{1'b1}}}) return {1'b0, {47{1'b1}}};
    return q[QW-1:0];
  endfunction

endpackage

FILE: hdl/blf_mul.sv
// Shift-add multiplier, one bit of b per cycle, 128 x 64 to 192 bits.
// Uses no package.
module blf_mul (
  input  logic         clk,
  input  logic         rst,
  input  logic         go,
  input  logic [127:0] a,
  input  logic [63:0]  b,
  output logic [191:0] prod,
  output logic         done
);

  logic [191:0] ma;
  logic [63:0]  mb;
  logic [5:0]   cnt;
  logic         run;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + 6'd1;
        if (cnt == 6'd63) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      prod <= '0;
      ma   <= {64'd0, a};
      mb   <= b;
    end else if (run) begin
      if (mb[0]) prod <= prod + ma;
      ma <= {ma[190:0], 1'b0};
      mb <= {1'b0, mb[63:1]};
    end
  end

endmodule

FILE: hdl/blf_div.sv
// Restoring divider, one quotient bit per cycle, 128 / 64 bits.
// Uses no package; the divisor must be nonzero and below 2^63.
module blf_div (
  input  logic         clk,
  input  logic         rst,
  input  logic         go,
  input  logic [127:0] n,
  input  logic [63:0]  d,
  output logic [127:0] quo,
  output logic         done
);

  logic [63:0] rem;
  logic [63:0] d_r;
  logic [64:0] rs;
  logic [6:0]  cnt;
  logic        run;

  assign rs = {rem, quo[127]};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + 7'd1;
        if (cnt == 7'd127) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      rem <= '0;
      quo <= n;
      d_r <= d;
    end else if (run) begin
      if (rs >= {1'b0, d_r}) begin
        rem <= 64'(rs - {1'b0, d_r});
        quo <= {quo[126:0], 1'b1};
      end else begin
        rem <= rs[63:0];
        quo <= {quo[126:0], 1'b0};
      end
    end
  end

endmodule

FILE: hdl/blf_ctrl.sv
// Sequencer of the linear fit block: accumulate, finish scan, solve, predict.
// Depends on blf_pkg.
module blf_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [1:0]          action,
  output logic                busy,
  output blf_pkg::dp_cmd_t    cmd,
  input  blf_pkg::dp_stat_t   stat
);

  blf_pkg::state_t      state, state_next;
  blf_pkg::step_t       step, step_next;
  blf_pkg::fit_status_t fstat, fstat_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= blf_pkg::S_IDLE;
      step  <= blf_pkg::STEP_P1;
      fstat <= blf_pkg::FIT_OK;
    end else begin
      state <= state_next;
      step  <= step_next;
      fstat <= fstat_next;
    end
  end

  always_comb begin
    state_next = state;
    step_next  = step;
    fstat_next = fstat;
    case (state)
      blf_pkg::S_IDLE: begin
        if (start) begin
          case (blf_pkg::action_t'(action))
            blf_pkg::ACT_HEADER: state_next = blf_pkg::S_HDR_A;
            blf_pkg::ACT_VALUE:  state_next = blf_pkg::S_VAL_A;
            blf_pkg::ACT_FINISH: state_next = blf_pkg::S_FIN;
            default:             state_next = blf_pkg::S_PRED_A;
          endcase
        end
      end
      blf_pkg::S_HDR_A:  state_next = blf_pkg::S_HDR_B;
      blf_pkg::S_HDR_B:  state_next = blf_pkg::S_IDLE;
      blf_pkg::S_VAL_A:  state_next = blf_pkg::S_VAL_B;
      blf_pkg::S_VAL_B:  state_next = blf_pkg::S_VAL_C;
      blf_pkg::S_VAL_C:  state_next = blf_pkg::S_IDLE;
      blf_pkg::S_PRED_A: state_next = blf_pkg::S_PRED_B;
      blf_pkg::S_PRED_B: state_next = blf_pkg::S_IDLE;
      blf_pkg::S_FIN: begin
        if (stat.overflow) begin
          fstat_next = blf_pkg::FIT_OVERFLOW;
          state_next = blf_pkg::S_EMIT;
        end else if (stat.w_zero) begin
          fstat_next = blf_pkg::FIT_ZERO_W;
          state_next = blf_pkg::S_EMIT;
        end else begin
          state_next = blf_pkg::S_SCAN;
        end
      end
      blf_pkg::S_SCAN: begin
        if (stat.scan_end) begin
          if (stat.found) begin
            step_next  = blf_pkg::STEP_SLOPE;
            state_next = blf_pkg::S_GO;
          end else begin
            fstat_next = blf_pkg::FIT_NO_ATTR;
            state_next = blf_pkg::S_EMIT;
          end
        end else begin
          step_next  = blf_pkg::STEP_P1;
          state_next = blf_pkg::S_GO;
        end
      end
      blf_pkg::S_GO: state_next = blf_pkg::S_WAIT;
      blf_pkg::S_WAIT: begin
        if (stat.unit_done) begin
          state_next = blf_pkg::S_GO;
          case (step)
            blf_pkg::STEP_P1:    step_next = blf_pkg::STEP_P2;
            blf_pkg::STEP_P2:    step_next = blf_pkg::STEP_P3;
            blf_pkg::STEP_P3:    step_next = blf_pkg::STEP_P4;
            blf_pkg::STEP_P4:    state_next = blf_pkg::S_JUDGE;
            blf_pkg::STEP_C1:    step_next = blf_pkg::STEP_C2;
            blf_pkg::STEP_C2:    step_next = blf_pkg::STEP_B1;
            blf_pkg::STEP_B1:    step_next = blf_pkg::STEP_B2;
            blf_pkg::STEP_B2:    state_next = blf_pkg::S_JUDGE2;
            blf_pkg::STEP_SLOPE: step_next = blf_pkg::STEP_PI;
            blf_pkg::STEP_PI:    step_next = blf_pkg::STEP_ICPT;
            default: begin
              fstat_next = blf_pkg::FIT_OK;
              state_next = blf_pkg::S_EMIT;
            end
          endcase
        end
      end
      blf_pkg::S_JUDGE: begin
        if (stat.sxx_zero) begin
          state_next = blf_pkg::S_NEXT;
        end else if (!stat.found) begin
          state_next = blf_pkg::S_TAKE;
        end else begin
          step_next  = blf_pkg::STEP_C1;
          state_next = blf_pkg::S_GO;
        end
      end
      blf_pkg::S_JUDGE2: state_next = stat.better ? blf_pkg::S_TAKE : blf_pkg::S_NEXT;
      blf_pkg::S_TAKE:   state_next = blf_pkg::S_NEXT;
      blf_pkg::S_NEXT:   state_next = blf_pkg::S_SCAN;
      blf_pkg::S_EMIT:   state_next = blf_pkg::S_IDLE;
      default:           state_next = blf_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd            = '0;
    cmd.step       = step;
    cmd.fit_status = fstat;
    busy           = (state != blf_pkg::S_IDLE);
    case (state)
      blf_pkg::S_IDLE:   cmd.load       = start;
      blf_pkg::S_HDR_B:  cmd.hdr_commit = 1'b1;
      blf_pkg::S_VAL_C:  cmd.val_commit = 1'b1;
      blf_pkg::S_PRED_B: cmd.pred_emit  = 1'b1;
      blf_pkg::S_FIN:    cmd.fin_clear  = 1'b1;
      blf_pkg::S_GO:     cmd.go         = 1'b1;
      blf_pkg::S_TAKE:   cmd.take       = 1'b1;
      blf_pkg::S_NEXT:   cmd.cnt_inc    = 1'b1;
      blf_pkg::S_EMIT:   cmd.fit_emit   = 1'b1;
      default: ;
    endcase
  end

endmodule

FILE: hdl/blf_dp.sv
// Datapath of the linear fit block: config, moment sums, fit and predict math.
// Depends on blf_pkg, blf_mul and blf_div.
module blf_dp #(
  parameter int MAX_ATTRS     = 16,
  parameter int MAX_INSTANCES = 4096,
  parameter int FRAC_BITS     = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic                       cfg_addr,
  input  logic [4:0]                 cfg_wdata,
  input  logic [1:0]                 action,
  input  logic [3:0]                 attr_index,
  input  logic signed [11:0]         x_value,
  input  logic signed [11:0]         y_label,
  input  logic [7:0]                 weight,
  input  blf_pkg::dp_cmd_t           cmd,
  output blf_pkg::dp_stat_t          stat,
  output logic                       done,
  output logic                       result_kind,
  output logic [1:0]                 status,
  output logic [3:0]                 chosen_attr,
  output logic signed [blf_pkg::QW-1:0] slope_q,
  output logic signed [blf_pkg::QW-1:0] intercept_q,
  output logic signed [blf_pkg::QW-1:0] prediction_q
);

  localparam int AW  = (MAX_ATTRS > 1) ? $clog2(MAX_ATTRS) : 1;
  localparam int CW  = $clog2(MAX_ATTRS + 1);
  localparam int ICW = $clog2(MAX_INSTANCES + 1);
  localparam int QW  = blf_pkg::QW;

  logic       use_weights;
  logic [4:0] num_attributes;
  logic [CW-1:0] lim;

  logic [3:0]         it_attr;
  logic signed [11:0] it_x, it_y;
  logic [7:0]         it_w;
  logic               it_unused_action;

  logic [20:0]        total_w;
  logic signed [32:0] sum_wy;
  logic signed [32:0] sum_wx  [MAX_ATTRS];
  logic [42:0]        sum_wxx [MAX_ATTRS];
  logic signed [43:0] sum_wxy [MAX_ATTRS];
  logic signed [11:0] cur_label;
  logic [7:0]         cur_weight;
  logic [ICW-1:0]     inst_cnt;
  logic               overflow;
  logic [MAX_ATTRS-1:0] seen;

  logic [7:0]         wt, w_sel;
  logic               state_is_hdr;
  logic signed [11:0] v_sel;
  logic signed [20:0] m1;
  logic signed [32:0] m_xx, m_xy;
  logic               hdr_ovf, attr_ok;
  logic [AW-1:0]      item_ai, addr;

  logic [CW-1:0]      cnt;
  logic [AW-1:0]      best;
  logic               found, better;
  logic [63:0]        sxx, sxy, mag, bsxx, bmag;
  logic               bneg;
  logic signed [127:0] t1, sp, wy_sh;
  logic [191:0]       cmpc;
  logic signed [QW-1:0] slope_r, icpt_r;

  logic               model_valid;
  logic [AW-1:0]      model_attr;
  logic signed [QW-1:0] model_slope, model_icpt;
  logic signed [59:0] pm;
  logic signed [60:0] psum;
  logic signed [QW-1:0] pred_sat;

  logic signed [32:0] rd_wx;
  logic [42:0]        rd_wxx;
  logic signed [43:0] rd_wxy;
  logic [32:0]        abs_wx, abs_wy;
  logic [43:0]        abs_wxy;
  logic [QW-1:0]      abs_sl;

  logic [127:0] mul_a;
  logic [63:0]  mul_b;
  logic         mul_neg, mul_go, mul_done;
  logic [191:0] prod;
  logic [127:0] div_n, quo;
  logic [63:0]  div_d;
  logic         div_go, div_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      use_weights    <= 1'b0;
      num_attributes <= 5'd16;
    end else if (cfg_we) begin
      case (cfg_addr)
        blf_pkg::CFG_USE_WEIGHTS: use_weights    <= cfg_wdata[0];
        blf_pkg::CFG_NUM_ATTRS:   num_attributes <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign lim = (7'(num_attributes) < 7'(MAX_ATTRS)) ? CW'(num_attributes) : CW'(MAX_ATTRS);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      it_unused_action <= action[0];
      it_attr <= attr_index;
      it_x    <= x_value;
      it_y    <= y_label;
      it_w    <= weight;
    end
  end

  // Header and value products, one multiply deep per register stage.
  assign wt           = use_weights ? it_w : 8'd1;
  assign state_is_hdr = !it_unused_action;
  assign w_sel        = state_is_hdr ? wt : cur_weight;
  assign v_sel        = state_is_hdr ? it_y : it_x;
  assign hdr_ovf      = (inst_cnt >= ICW'(MAX_INSTANCES));
  assign item_ai      = AW'(it_attr);
  assign attr_ok      = (8'(it_attr) < 8'(lim)) && !seen[item_ai];

  always_ff @(posedge clk) begin
    m1   <= $signed({1'b0, w_sel}) * v_sel;
    m_xx <= m1 * it_x;
    m_xy <= m1 * cur_label;
    pm   <= it_x * model_slope;
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.fit_emit) begin
      total_w    <= '0;
      sum_wy     <= '0;
      cur_label  <= '0;
      cur_weight <= '0;
      inst_cnt   <= '0;
      overflow   <= 1'b0;
      seen       <= '0;
      for (int i = 0; i < MAX_ATTRS; i++) begin
        sum_wx[i]  <= '0;
        sum_wxx[i] <= '0;
        sum_wxy[i] <= '0;
      end
    end else if (cmd.hdr_commit) begin
      seen <= '0;
      if (hdr_ovf) begin
        overflow   <= 1'b1;
        cur_weight <= '0;
        cur_label  <= '0;
      end else begin
        cur_weight <= wt;
        cur_label  <= it_y;
        inst_cnt   <= inst_cnt + ICW'(1);
        total_w    <= total_w + 21'(wt);
        sum_wy     <= sum_wy + 33'(m1);
      end
    end else if (cmd.val_commit && attr_ok) begin
      seen[item_ai]    <= 1'b1;
      sum_wx[item_ai]  <= sum_wx[item_ai] + 33'(m1);
      sum_wxx[item_ai] <= sum_wxx[item_ai] + {10'd0, m_xx};
      sum_wxy[item_ai] <= sum_wxy[item_ai] + 44'(m_xy);
    end
  end

  // Single read port over the moment arrays.
  assign addr    = cmd.val_commit ? item_ai :
                   ((cmd.step == blf_pkg::STEP_PI) ? best : cnt[AW-1:0]);
  assign rd_wx   = sum_wx[addr];
  assign rd_wxx  = sum_wxx[addr];
  assign rd_wxy  = sum_wxy[addr];
  assign abs_wx  = rd_wx[32] ? 33'(-rd_wx) : rd_wx;
  assign abs_wy  = sum_wy[32] ? 33'(-sum_wy) : sum_wy;
  assign abs_wxy = rd_wxy[43] ? 44'(-rd_wxy) : rd_wxy;
  assign abs_sl  = slope_r[QW-1] ? QW'(-slope_r) : slope_r;
  assign mag     = sxy[63] ? (~sxy + 64'd1) : sxy;
  assign wy_sh   = 128'(sum_wy) <<< FRAC_BITS;

  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    mul_neg = 1'b0;
    div_n   = '0;
    div_d   = '0;
    case (cmd.step)
      blf_pkg::STEP_P1: begin
        mul_a = 128'(total_w);
        mul_b = 64'(rd_wxx);
      end
      blf_pkg::STEP_P2: begin
        mul_a = 128'(abs_wx);
        mul_b = 64'(abs_wx);
      end
      blf_pkg::STEP_P3: begin
        mul_a   = 128'(total_w);
        mul_b   = 64'(abs_wxy);
        mul_neg = rd_wxy[43];
      end
      blf_pkg::STEP_P4: begin
        mul_a   = 128'(abs_wx);
        mul_b   = 64'(abs_wy);
        mul_neg = rd_wx[32] ^ sum_wy[32];
      end
      blf_pkg::STEP_C1: begin
        mul_a = 128'(mag);
        mul_b = mag;
      end
      blf_pkg::STEP_C2: begin
        mul_a = t1;
        mul_b = bsxx;
      end
      blf_pkg::STEP_B1: begin
        mul_a = 128'(bmag);
        mul_b = bmag;
      end
      blf_pkg::STEP_B2: begin
        mul_a = t1;
        mul_b = sxx;
      end
      blf_pkg::STEP_SLOPE: begin
        div_n = 128'(bmag) << FRAC_BITS;
        div_d = bsxx;
      end
      blf_pkg::STEP_PI: begin
        mul_a   = 128'(abs_sl);
        mul_b   = 64'(abs_wx);
        mul_neg = slope_r[QW-1] ^ rd_wx[32];
      end
      blf_pkg::STEP_ICPT: begin
        div_n = t1[127] ? 128'(-t1) : t1;
        div_d = 64'(total_w);
      end
      default: ;
    endcase
  end

  assign div_go = cmd.go && (cmd.step == blf_pkg::STEP_SLOPE ||
                             cmd.step == blf_pkg::STEP_ICPT);
  assign mul_go = cmd.go && !div_go;
  assign sp     = mul_neg ? 128'(-$signed(prod[127:0])) : $signed(prod[127:0]);

  blf_mul u_mul (
    .clk  (clk),
    .rst  (rst),
    .go   (mul_go),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod),
    .done (mul_done)
  );

  blf_div u_div (
    .clk  (clk),
    .rst  (rst),
    .go   (div_go),
    .n    (div_n),
    .d    (div_d),
    .quo  (quo),
    .done (div_done)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt   <= '0;
      found <= 1'b0;
    end else if (cmd.fin_clear) begin
      cnt   <= '0;
      found <= 1'b0;
    end else if (cmd.cnt_inc) begin
      cnt <= cnt + CW'(1);
    end else if (cmd.take) begin
      found <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      best <= cnt[AW-1:0];
      bsxx <= sxx;
      bmag <= mag;
      bneg <= sxy[63];
    end
    if (mul_done || div_done) begin
      case (cmd.step)
        blf_pkg::STEP_P1:    t1 <= $signed(prod[127:0]);
        blf_pkg::STEP_P2:    sxx <= t1[63:0] - prod[63:0];
        blf_pkg::STEP_P3:    t1 <= sp;
        blf_pkg::STEP_P4:    sxy <= t1[63:0] - sp[63:0];
        blf_pkg::STEP_C1:    t1 <= $signed(prod[127:0]);
        blf_pkg::STEP_C2:    cmpc <= prod;
        blf_pkg::STEP_B1:    t1 <= $signed(prod[127:0]);
        blf_pkg::STEP_B2:    better <= (cmpc > prod);
        blf_pkg::STEP_SLOPE: slope_r <= blf_pkg::sat_q(quo, bneg);
        blf_pkg::STEP_PI:    t1 <= wy_sh - sp;
        blf_pkg::STEP_ICPT:  icpt_r <= blf_pkg::sat_q(quo, t1[127]);
        default: ;
      endcase
    end
  end

  assign stat.overflow  = overflow;
  assign stat.w_zero    = (total_w == '0);
  assign stat.scan_end  = (cnt >= lim);
  assign stat.sxx_zero  = (sxx == '0);
  assign stat.found     = found;
  assign stat.better    = better;
  assign stat.unit_done = mul_done || div_done;

  assign psum     = 61'(pm) + 61'(model_icpt);
  assign pred_sat = (psum > 61'sh7FFF_FFFF_FFFF) ? {1'b0, {47{1'b1}}} :
                    (psum < -61'sh8000_0000_0000) ? {1'b1, 47'd0} : psum[QW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      done        <= 1'b0;
      model_valid <= 1'b0;
      model_attr  <= '0;
      model_slope <= '0;
      model_icpt  <= '0;
    end else begin
      done <= cmd.fit_emit || cmd.pred_emit;
      if (cmd.fit_emit) begin
        if (cmd.fit_status == blf_pkg::FIT_OK) begin
          model_valid <= 1'b1;
          model_attr  <= best;
          model_slope <= slope_r;
          model_icpt  <= icpt_r;
        end else begin
          model_valid <= 1'b0;
          model_attr  <= '0;
          model_slope <= '0;
          model_icpt  <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fit_emit) begin
      result_kind  <= 1'b0;
      status       <= cmd.fit_status;
      prediction_q <= '0;
      if (cmd.fit_status == blf_pkg::FIT_OK) begin
        chosen_attr <= 4'(best);
        slope_q     <= slope_r;
        intercept_q <= icpt_r;
      end else begin
        chosen_attr <= '0;
        slope_q     <= '0;
        intercept_q <= '0;
      end
    end else if (cmd.pred_emit) begin
      result_kind <= 1'b1;
      slope_q     <= '0;
      intercept_q <= '0;
      if (model_valid) begin
        status       <= blf_pkg::FIT_OK;
        chosen_attr  <= 4'(model_attr);
        prediction_q <= pred_sat;
      end else begin
        status       <= blf_pkg::FIT_NO_ATTR;
        chosen_attr  <= '0;
        prediction_q <= '0;
      end
    end
  end

endmodule

FILE: hdl/best_attribute_linear_fit.sv
// Top level of the weighted best-attribute linear fit block.
// Depends on blf_pkg, blf_ctrl and blf_dp.
//
// Usage: drive action, attr_index, x_value, y_label and weight with start high;
// the item is taken at a rising edge where busy is low. An attribute value
// is two registered multiplies, then the sum update. A predict ends in a
// one-cycle done strobe with the result fields. Unless an overflow or a zero
// total weight ends it first, a finish walks every attribute in use through
// the shared shift-add multiplier: 4 products per attribute, 4 more when a
// candidate is compared, then, if one was found, two divisions and one
// product for slope and intercept. done pulses for exactly one cycle per
// finish or predict and cannot be held off by the receiver; the fields hold
// until the next result. Configuration (cfg_we, cfg_addr, cfg_wdata) is
// written while the block is idle. Reset clears all sums, drops the model,
// sets use_weights to 0 and num_attributes to 16.
module best_attribute_linear_fit #(
  parameter int MAX_ATTRS     = 16,
  parameter int MAX_INSTANCES = 4096,
  parameter int FRAC_BITS     = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic [1:0]           action,
  input  logic [3:0]           attr_index,
  input  logic signed [11:0]   x_value,
  input  logic signed [11:0]   y_label,
  input  logic [7:0]           weight,
  input  logic                 cfg_we,
  input  logic                 cfg_addr,
  input  logic [4:0]           cfg_wdata,
  output logic                 done,
  output logic                 result_kind,
  output logic [1:0]           status,
  output logic [3:0]           chosen_attr,
  output logic signed [47:0]   slope_q,
  output logic signed [47:0]   intercept_q,
  output logic signed [47:0]   prediction_q
);

  blf_pkg::dp_cmd_t  cmd;
  blf_pkg::dp_stat_t stat;

  blf_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .action (action),
    .busy   (busy),
    .cmd    (cmd),
    .stat   (stat)
  );

  blf_dp #(
    .MAX_ATTRS     (MAX_ATTRS),
    .MAX_INSTANCES (MAX_INSTANCES),
    .FRAC_BITS     (FRAC_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_addr     (cfg_addr),
    .cfg_wdata    (cfg_wdata),
    .action       (action),
    .attr_index   (attr_index),
    .x_value      (x_value),
    .y_label      (y_label),
    .weight       (weight),
    .cmd          (cmd),
    .stat         (stat),
    .done         (done),
    .result_kind  (result_kind),
    .status       (status),
    .chosen_attr  (chosen_attr),
    .slope_q      (slope_q),
    .intercept_q  (intercept_q),
    .prediction_q (prediction_q)
  );

endmodule

FILE: hdl/blf_checker.sv
// Port-level checks of the linear fit block, bound to its top level.
// Depends on blf_pkg and best_attribute_linear_fit_defines.svh.
`include "best_attribute_linear_fit_defines.svh"

module blf_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic        result_kind,
  input logic [1:0]  status,
  input logic [3:0]  chosen_attr,
  input logic [47:0] slope_q,
  input logic [47:0] intercept_q
);

  logic fit_fail, fields_zero;

  assign fit_fail    = done && !result_kind && (status != blf_pkg::FIT_OK);
  assign fields_zero = (slope_q == '0) && (intercept_q == '0);

  `BLF_CHECK(a_done_single, done |=> !done, "result strobe longer than one cycle")
  `BLF_CHECK(a_accept_busy, (start && !busy) |=> busy, "accepted item did not raise busy")
  `BLF_CHECK(a_done_after_work, done |-> $past(busy), "result without work in progress")
  `BLF_CHECK(a_fail_zero, fit_fail |-> (fields_zero && chosen_attr == '0), "failed fit fields")
  `BLF_CHECK(a_pred_fields, (done && result_kind) |-> fields_zero, "prediction carries fit fields")

endmodule

bind best_attribute_linear_fit blf_checker u_blf_checker (.*);
